/* design/hlt_pkg.sv */
// Shared constants, status codes and control/status structs of the hashed lookup table.
package hlt_pkg;

	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 10;
	localparam int COUNT_W  = 11;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INSERT = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

	// Register index (byte address / 4)
	localparam logic [PADDR_W-3:0] REG_UPPER_BOUND = 1'b0;

	localparam logic [KEY_W-1:0] HASH_MULT         = 32'd2654435761;
	localparam logic [KEY_W-1:0] LOW_LIMIT         = 32'h0000_1000;
	localparam logic [KEY_W-1:0] UPPER_BOUND_RESET = 32'hFFFF_FFFF;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_step;  // write one empty slot during the clearing pass
		logic capture;     // take the key of an input transfer
		logic hash;        // range check and hash into the probe pointer
		logic read_first;  // read the home slot
		logic probe_step;  // miss: advance to the next slot
		logic insert;      // write the key into the empty slot
		logic hit;         // record a hit
		logic full;        // record a full table
		logic load_out;    // move the result into the output register
	} hlt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic reject;
		logic slot_valid;
		logic key_match;
		logic probe_last;
		logic out_free;
	} hlt_stat_t;

endpackage

/* design/hlt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hlt_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/hlt_ctrl.sv */
// Controller state machine: clearing pass, hashing, probe loop and result hand-off.
module hlt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hlt_pkg::hlt_stat_t st,
	output hlt_pkg::hlt_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				state_d  = st.reject ? S_DONE : S_READ;
			end
			S_READ: begin
				cmd.read_first = 1'b1;
				state_d        = S_PROBE;
			end
			S_PROBE: begin
				if (!st.slot_valid) begin
					cmd.insert = 1'b1;
					state_d    = S_DONE;
				end else if (st.key_match) begin
					cmd.hit = 1'b1;
					state_d = S_DONE;
				end else if (st.probe_last) begin
					cmd.full = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/hlt_dp.sv */
// Datapath: key and probe registers, hash, slot RAM, entry count and output register.
module hlt_dp #(
	parameter int TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hlt_pkg::hlt_cmd_t             cmd,
	output hlt_pkg::hlt_stat_t            st,
	input  logic [hlt_pkg::KEY_W-1:0]     key,
	input  logic [hlt_pkg::KEY_W-1:0]     upper_bound,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hlt_pkg::STATUS_W-1:0]  status,
	output logic [hlt_pkg::HANDLE_W-1:0]  handle,
	output logic [hlt_pkg::COUNT_W-1:0]   entry_count
);

	localparam int SLOT_W = 1 + hlt_pkg::KEY_W + TABLE_BITS;
	localparam int DEPTH  = 1 << TABLE_BITS;
	localparam logic [TABLE_BITS-1:0] MULT_LO = hlt_pkg::HASH_MULT[TABLE_BITS-1:0];

	logic [hlt_pkg::KEY_W-1:0]    key_q;
	logic [TABLE_BITS-1:0]        pos_q;
	logic [TABLE_BITS-1:0]        probe_n_q;
	logic [TABLE_BITS:0]          count_q;
	logic [hlt_pkg::STATUS_W-1:0] res_status_q;
	logic [TABLE_BITS-1:0]        res_handle_q;
	logic                         out_valid_q;
	logic [hlt_pkg::STATUS_W-1:0] status_q;
	logic [hlt_pkg::HANDLE_W-1:0] handle_q;
	logic [hlt_pkg::COUNT_W-1:0]  entry_count_q;

	logic [TABLE_BITS-1:0] hash_d;
	logic [TABLE_BITS-1:0] pos_inc;
	logic                  reject_d;
	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_data;
	logic [TABLE_BITS-1:0] rd_addr;
	logic [SLOT_W-1:0]     rd_data;
	logic                  rd_valid;
	logic [hlt_pkg::KEY_W-1:0] rd_key;
	logic [TABLE_BITS-1:0] rd_handle;

	// Hash: low table bits of key * multiplier depend only on the low key bits
	assign hash_d   = key_q[TABLE_BITS-1:0] * MULT_LO;
	assign reject_d = (key_q < hlt_pkg::LOW_LIMIT) || (key_q >= upper_bound);
	assign pos_inc  = pos_q + 1'b1;

	// Slot word: valid, key, handle
	assign rd_valid  = rd_data[SLOT_W-1];
	assign rd_key    = rd_data[SLOT_W-2 -: hlt_pkg::KEY_W];
	assign rd_handle = rd_data[TABLE_BITS-1:0];

	assign wr_en   = cmd.clear_step | cmd.insert;
	assign wr_data = cmd.clear_step ? '0 : {1'b1, key_q, count_q[TABLE_BITS-1:0]};
	// Home slot first, then the following slot is read while the current one is checked
	assign rd_addr = cmd.read_first ? pos_q : pos_inc;

	hlt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Status back to the controller
	always_comb begin
		st            = '0;
		st.clear_last = &pos_q;
		st.reject     = reject_d;
		st.slot_valid = rd_valid;
		st.key_match  = (rd_key == key_q);
		st.probe_last = &probe_n_q;
		st.out_free   = !out_valid_q || !out_stall;
	end

	// Probe pointer (also the clearing sweep address) and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clear_step || cmd.probe_step) begin
				pos_q <= pos_inc;
			end else if (cmd.hash) begin
				pos_q <= hash_d;
			end
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Key, probe length and pending result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= key;
		end
		if (cmd.read_first) begin
			probe_n_q <= '0;
		end else if (cmd.probe_step) begin
			probe_n_q <= probe_n_q + 1'b1;
		end
		if (cmd.hash) begin
			res_status_q <= hlt_pkg::STATUS_REJECT;
			res_handle_q <= '0;
		end else if (cmd.insert) begin
			res_status_q <= hlt_pkg::STATUS_INSERT;
			res_handle_q <= count_q[TABLE_BITS-1:0];
		end else if (cmd.hit) begin
			res_status_q <= hlt_pkg::STATUS_HIT;
			res_handle_q <= rd_handle;
		end else if (cmd.full) begin
			res_status_q <= hlt_pkg::STATUS_FULL;
			res_handle_q <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			handle_q      <= hlt_pkg::HANDLE_W'(res_handle_q);
			entry_count_q <= hlt_pkg::COUNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign handle      = handle_q;
	assign entry_count = entry_count_q;

endmodule

/* design/hashed_lookup_or_insert_table.sv */
// Top level of the hashed lookup-or-insert table: register port, controller and datapath.
//
//   Channel   Signals                                   Direction
//   in        in_valid, in_stall, key                   item in
//   out       out_valid, out_stall, status, handle,     result out
//             entry_count
//   cfg       psel, penable, pwrite, paddr, pwdata,     register access
//             prdata, pready
//
// A result reaches the output register after its key is hashed and P slots are probed (P from
// 1 to 2^TABLE_BITS); the slot RAM read port checks one slot per cycle. A range-rejected key
// skips the probe. Loading waits while out_stall holds the last result. The next item is taken the
// cycle after the result is loaded, so an item is not taken before the last one is done.
// After reset a clearing pass writes every slot empty, with in_stall high.
// A result held by out_stall stays in the output register while the next item is worked on.
module hashed_lookup_or_insert_table #(
	parameter int TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hlt_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hlt_pkg::STATUS_W-1:0]  status,
	output logic [hlt_pkg::HANDLE_W-1:0]  handle,
	output logic [hlt_pkg::COUNT_W-1:0]   entry_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hlt_pkg::PADDR_W-1:0]   paddr,
	input  logic [hlt_pkg::PDATA_W-1:0]   pwdata,
	output logic [hlt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [hlt_pkg::KEY_W-1:0] upper_bound_q;
	logic                      reg_sel;
	hlt_pkg::hlt_cmd_t         cmd;
	hlt_pkg::hlt_stat_t        st;

	// Register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[hlt_pkg::PADDR_W-1:2] == hlt_pkg::REG_UPPER_BOUND);
	assign prdata  = reg_sel ? upper_bound_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_bound_q <= hlt_pkg::UPPER_BOUND_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			upper_bound_q <= pwdata;
		end
	end

	hlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	hlt_dp #(
		.TABLE_BITS(TABLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.key         (key),
		.upper_bound (upper_bound_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.handle      (handle),
		.entry_count (entry_count)
	);

endmodule

/* bench/tb.sv */
// Self-checking bench for the hashed lookup-or-insert table: random traffic, scoreboard, APB setup.
`timescale 1ns / 1ps

module tb;

	localparam int          TBL_BITS  = 10;
	localparam int unsigned SLOTS     = 1 << TBL_BITS;
	localparam int unsigned LIMIT     = 6_000_000;
	localparam int unsigned TAIL_WAIT = SLOTS + 80;
	localparam logic [hlt_pkg::PADDR_W-1:0] BOUND_ADDR = {hlt_pkg::REG_UPPER_BOUND, 2'b00};

	typedef struct packed {
		logic [hlt_pkg::STATUS_W-1:0] status;
		logic [hlt_pkg::HANDLE_W-1:0] handle;
		logic [hlt_pkg::COUNT_W-1:0]  count;
	} lookup_result_t;

	logic                         clk     = 1'b0;
	logic                         arst_n  = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [hlt_pkg::KEY_W-1:0]    key     = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [hlt_pkg::STATUS_W-1:0] status;
	logic [hlt_pkg::HANDLE_W-1:0] handle;
	logic [hlt_pkg::COUNT_W-1:0]  entry_count;
	logic                         psel    = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite  = 1'b0;
	logic [hlt_pkg::PADDR_W-1:0]  paddr   = '0;
	logic [hlt_pkg::PDATA_W-1:0]  pwdata  = '0;
	logic [hlt_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	hashed_lookup_or_insert_table #(.TABLE_BITS(TBL_BITS)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.handle      (handle),
		.entry_count (entry_count),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the table, the count and the range register
	logic                         slot_used   [SLOTS];
	logic [hlt_pkg::KEY_W-1:0]    slot_key    [SLOTS];
	logic [hlt_pkg::HANDLE_W-1:0] slot_handle [SLOTS];
	int unsigned                  stored_cnt  = 0;
	logic [hlt_pkg::KEY_W-1:0]    range_limit = hlt_pkg::UPPER_BOUND_RESET;

	logic [hlt_pkg::KEY_W-1:0]  pending_keys[$];
	lookup_result_t             expected_results[$];
	logic [hlt_pkg::KEY_W-1:0]  seen_keys[$];

	int unsigned errors       = 0;
	int unsigned cycle_cnt    = 0;
	int unsigned bound_writes = 0;
	int unsigned n_reject = 0, n_hit = 0, n_insert = 0, n_full = 0;

	// Probe the shadow table for one accepted key; insert on an empty slot
	function automatic lookup_result_t lookup_or_insert(input logic [hlt_pkg::KEY_W-1:0] k);
		lookup_result_t res;
		logic [hlt_pkg::KEY_W-1:0] prod;
		int unsigned pos;
		int unsigned n;
		res.status = hlt_pkg::STATUS_FULL;
		res.handle = '0;
		if (k < hlt_pkg::LOW_LIMIT || k >= range_limit) begin
			res.status = hlt_pkg::STATUS_REJECT;
		end else begin
			prod = k * hlt_pkg::HASH_MULT;
			pos  = prod & (SLOTS - 1);
			for (n = 0; n < SLOTS; n++) begin
				if (!slot_used[pos]) begin
					slot_used[pos]   = 1'b1;
					slot_key[pos]    = k;
					slot_handle[pos] = stored_cnt[hlt_pkg::HANDLE_W-1:0];
					res.handle       = stored_cnt[hlt_pkg::HANDLE_W-1:0];
					stored_cnt++;
					res.status       = hlt_pkg::STATUS_INSERT;
					break;
				end
				if (slot_key[pos] == k) begin
					res.handle = slot_handle[pos];
					res.status = hlt_pkg::STATUS_HIT;
					break;
				end
				pos = (pos + 1) & (SLOTS - 1);
			end
		end
		res.count = stored_cnt[hlt_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// Key mix: fresh in-range keys, repeats, same-home-slot keys, out-of-range keys
	function automatic logic [hlt_pkg::KEY_W-1:0] pick_key(input int unsigned fresh_w);
		int unsigned r;
		logic [hlt_pkg::KEY_W-1:0] k;
		logic [hlt_pkg::KEY_W-1:0] base;
		r = $urandom_range(99, 0);
		if (range_limit <= hlt_pkg::LOW_LIMIT) begin
			k = $urandom;
		end else if (r < fresh_w || seen_keys.size() == 0) begin
			k = $urandom_range(range_limit - 1, hlt_pkg::LOW_LIMIT);
			seen_keys.push_back(k);
		end else if (r < fresh_w + (100 - fresh_w) / 2) begin
			k = seen_keys[$urandom_range(seen_keys.size() - 1, 0)];
		end else if (r < fresh_w + 3 * (100 - fresh_w) / 4) begin
			// same home slot as a known key, lengthens the probe chain
			base = seen_keys[$urandom_range(seen_keys.size() - 1, 0)];
			k = base + SLOTS * $urandom_range(8, 1);
			if (k < hlt_pkg::LOW_LIMIT || k >= range_limit)
				k = base;
			else
				seen_keys.push_back(k);
		end else if ($urandom_range(1, 0) == 0) begin
			k = $urandom_range(hlt_pkg::LOW_LIMIT - 1, 0);
		end else begin
			k = $urandom_range(32'hFFFF_FFFF, range_limit);
		end
		return k;
	endfunction

	// APB write of the range register, then a read back
	task automatic write_upper_bound(input logic [hlt_pkg::KEY_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BOUND_ADDR;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		range_limit = val;
		bound_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			$error("upper_bound read back: expected %h, actual %h", val, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Hold off until every queued key went in and every result came back;
	// checked at the falling edge so the driver and monitor updates have settled
	task automatic wait_drained;
		do @(negedge clk);
		while (pending_keys.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic queue_random(input int unsigned n, input int unsigned fresh_w);
		for (int unsigned i = 0; i < n; i++)
			pending_keys.push_back(pick_key(fresh_w));
		wait_drained();
	endtask

	// Input driver: bursts of transfers separated by random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(lookup_or_insert(key));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_keys.size() != 0) begin
					key      <= pending_keys.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(16, 1);
						case ($urandom_range(9, 0))
							0, 1, 2, 3: gap_left = 0;
							9:          gap_left = $urandom_range(60, 20);
							default:    gap_left = $urandom_range(8, 1);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output stall pattern: modes of random length
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3, 0);
			stall_left = $urandom_range(300, 20);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(3, 0) == 0);
			2:       out_stall <= ($urandom_range(3, 0) != 0);
			default: out_stall <= ~out_stall;
		endcase
	end

	// Result monitor and scoreboard
	lookup_result_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: status %0d handle %0d entry_count %0d",
					status, handle, entry_count);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
				if (handle !== want.handle) begin
					$error("handle: expected %0d, actual %0d", want.handle, handle);
					errors++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, actual %0d", want.count, entry_count);
					errors++;
				end
				case (want.status)
					hlt_pkg::STATUS_REJECT: n_reject++;
					hlt_pkg::STATUS_HIT:    n_hit++;
					hlt_pkg::STATUS_INSERT: n_insert++;
					default:                n_full++;
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		logic [hlt_pkg::KEY_W-1:0] wrap_key;
		logic [hlt_pkg::KEY_W-1:0] prod;
		int unsigned               fill_n;

		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i]   = 1'b0;
			slot_key[i]    = '0;
			slot_handle[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// a key whose home slot is the last one, so its neighbor wraps to slot 0
		wrap_key = hlt_pkg::LOW_LIMIT;
		prod = wrap_key * hlt_pkg::HASH_MULT;
		while ((prod & (SLOTS - 1)) != SLOTS - 1) begin
			wrap_key++;
			prod = wrap_key * hlt_pkg::HASH_MULT;
		end

		// Directed: range edges, collisions, wrap, hit after probing
		pending_keys.push_back(32'h0000_0000);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT - 1);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT + SLOTS);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT + 2 * SLOTS);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT + SLOTS);
		pending_keys.push_back(wrap_key);
		pending_keys.push_back(wrap_key + SLOTS);
		pending_keys.push_back(wrap_key + SLOTS);
		pending_keys.push_back(32'hFFFF_FFFF);
		pending_keys.push_back(32'hFFFF_FFFE);
		pending_keys.push_back(32'hAAAA_AAAA);
		pending_keys.push_back(32'h5555_5555);
		wait_drained();

		write_upper_bound(32'h0000_0000);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT);
		pending_keys.push_back(32'hFFFF_FFFF);
		wait_drained();

		write_upper_bound(hlt_pkg::LOW_LIMIT + 1);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT + 1);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT - 1);
		wait_drained();

		write_upper_bound(hlt_pkg::LOW_LIMIT);
		pending_keys.push_back(hlt_pkg::LOW_LIMIT);
		wait_drained();

		// Random traffic at several range settings
		write_upper_bound($urandom_range(32'hFFFF_FFFE, 32'h0000_2000));
		queue_random(200, 35);
		write_upper_bound($urandom_range(32'hFFFF_FFFE, 32'h8000_0000));
		queue_random(100, 40);
		write_upper_bound(32'h0000_5000);
		queue_random(120, 40);

		// Fill the table to the brim and beyond
		write_upper_bound(hlt_pkg::UPPER_BOUND_RESET);
		fill_n = (SLOTS - stored_cnt) * 10 / 9 + 40;
		queue_random(fill_n, 90);

		// Full table: hits still hit, new keys report full
		write_upper_bound($urandom_range(32'hFFFF_FFF0, 32'h8000_0000));
		queue_random(120, 30);
		write_upper_bound(hlt_pkg::UPPER_BOUND_RESET);
		queue_random(100, 30);

		repeat (TAIL_WAIT) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		$display("checked %0d rejected, %0d hits, %0d inserts, %0d full-table results",
			n_reject, n_hit, n_insert, n_full);
		$display("upper_bound written %0d times, final entry count %0d", bound_writes,
			stored_cnt);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
